// ===== design/etsv_pkg.sv =====
package etsv_pkg;

	localparam int HEADER_LENGTH = 53;
	localparam logic [8*HEADER_LENGTH-1:0] HEADER_TEXT =
		{"document", "_id\tversion\tdeleted\ttitle\tbody\ttags\ttimestamp"};

	localparam logic [7:0] CH_NEWLINE   = 8'h0a;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0d;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_LOWER_T   = 8'h74;
	localparam logic [7:0] CH_LOWER_N   = 8'h6e;
	localparam logic [7:0] CH_LOWER_R   = 8'h72;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_ONE       = 8'h31;
	localparam logic [7:0] CH_NINE      = 8'h39;

	localparam logic [2:0] COLUMN_COUNT_M1 = 3'd6;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_ROW   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;
	localparam logic [1:0] KIND_DONE  = 2'd3;

	localparam logic [2:0] ERR_HEADER  = 3'd0;
	localparam logic [2:0] ERR_ESCAPE  = 3'd1;
	localparam logic [2:0] ERR_COLUMNS = 3'd2;
	localparam logic [2:0] ERR_ID      = 3'd3;
	localparam logic [2:0] ERR_VERSION = 3'd4;
	localparam logic [2:0] ERR_DELETED = 3'd5;

	// largest accumulator that still takes one more digit without overflow
	localparam logic [63:0] VER_LIMIT_LOW  = 64'd1844674407370955161;
	localparam logic [63:0] VER_LIMIT_HIGH = 64'd1844674407370955160;

	localparam int TDATA_BITS = 128;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [2:0]  column_index;
		logic [31:0] row_line;
		logic [63:0] version_value;
		logic        deleted_flag;
		logic [2:0]  error_code;
		logic [15:0] error_column;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

	function automatic logic [7:0] header_char(input logic [5:0] pos);
		logic [5:0] idx;
		idx = 6'(HEADER_LENGTH - 1) - pos;
		return HEADER_TEXT[8*idx +: 8];
	endfunction

endpackage

// ===== design/etsv_parse.sv =====
module etsv_parse #(
	parameter int LENGTH_BITS = 16,
	parameter int LINE_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic             cmd,
	input  logic [7:0]       file_byte,
	output etsv_pkg::push_t  push
);
	import etsv_pkg::*;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_ROWS   = 2'd1;
	localparam logic [1:0] PH_STOP   = 2'd2;

	logic [1:0]             phase_q, phase_n;
	logic [5:0]             hdr_pos_q, hdr_pos_n;
	logic                   hdr_bad_q, hdr_bad_n;
	logic [LINE_BITS-1:0]   line_q, line_n;
	logic [LENGTH_BITS-1:0] raw_len_q, raw_len_n;
	logic                   esc_q, esc_n;
	logic [2:0]             tabs_q, tabs_n;
	logic                   id_seen_q, id_seen_n;
	logic [63:0]            ver_q, ver_n;
	logic                   ver_bad_q, ver_bad_n;
	logic                   ver_dig_q, ver_dig_n;
	logic [1:0]             del_len_q, del_len_n;
	logic                   del_val_q, del_val_n;

	logic [63:0]  line_ext;
	logic [31:0]  line_num;
	logic [31:0]  len_ext;
	logic [15:0]  len_clamp;
	logic [7:0]   dec;
	logic         esc_ok;
	logic         is_digit;
	logic [3:0]   digit;
	logic [63:0]  ver_limit;
	logic [63:0]  ver_next;
	result_t      fin;
	logic         fin_err;
	result_t      data_res;
	result_t      done_res;
	result_t      res0, res1;
	logic [1:0]   n_res;

	assign line_ext  = 64'(line_q);
	assign line_num  = (line_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : line_ext[31:0];
	assign len_ext   = 32'(raw_len_q);
	assign len_clamp = (len_ext > 32'hFFFF) ? 16'hFFFF : len_ext[15:0];

	always_comb begin
		esc_ok = 1'b1;
		case (file_byte)
			CH_LOWER_T:   dec = CH_TAB;
			CH_LOWER_N:   dec = CH_NEWLINE;
			CH_LOWER_R:   dec = CH_CR;
			CH_BACKSLASH: dec = CH_BACKSLASH;
			default: begin
				dec = file_byte;
				esc_ok = 1'b0;
			end
		endcase
		if (!esc_q) begin
			dec = file_byte;
		end
	end

	assign is_digit  = (dec >= CH_ZERO) && (dec <= CH_NINE);
	assign digit     = 4'(dec - CH_ZERO);
	assign ver_limit = (digit > 4'd5) ? VER_LIMIT_HIGH : VER_LIMIT_LOW;
	assign ver_next  = {ver_q[60:0], 3'b000} + {ver_q[62:0], 1'b0} + 64'(digit);

	always_comb begin
		fin = '0;
		fin.row_line = line_num;
		fin.kind = KIND_ERROR;
		if (esc_q) begin
			fin.error_code = ERR_ESCAPE;
			fin.error_column = len_clamp;
		end else if (tabs_q != COLUMN_COUNT_M1) begin
			fin.error_code = ERR_COLUMNS;
			fin.error_column = len_clamp;
		end else if (!id_seen_q) begin
			fin.error_code = ERR_ID;
		end else if (ver_bad_q || !ver_dig_q || ver_q == 64'd0) begin
			fin.error_code = ERR_VERSION;
			fin.error_column = 16'd1;
		end else if (del_len_q != 2'd1) begin
			fin.error_code = ERR_DELETED;
			fin.error_column = 16'd2;
		end else begin
			fin.kind = KIND_ROW;
			fin.version_value = ver_q;
			fin.deleted_flag = del_val_q;
		end
		fin_err = (fin.kind == KIND_ERROR);
	end

	always_comb begin
		data_res = '0;
		data_res.kind = KIND_DATA;
		data_res.data_byte = dec;
		data_res.column_index = tabs_q;
		done_res = '0;
		done_res.kind = KIND_DONE;
	end

	always_comb begin
		phase_n   = phase_q;
		hdr_pos_n = hdr_pos_q;
		hdr_bad_n = hdr_bad_q;
		line_n    = line_q;
		raw_len_n = raw_len_q;
		esc_n     = esc_q;
		tabs_n    = tabs_q;
		id_seen_n = id_seen_q;
		ver_n     = ver_q;
		ver_bad_n = ver_bad_q;
		ver_dig_n = ver_dig_q;
		del_len_n = del_len_q;
		del_val_n = del_val_q;
		res0      = '0;
		res1      = '0;
		n_res     = 2'd0;

		if (fire) begin
			case (phase_q)
				PH_HEADER: begin
					if (!cmd && file_byte != CH_NEWLINE) begin
						if (hdr_pos_q < 6'(HEADER_LENGTH)) begin
							if (header_char(hdr_pos_q) != file_byte) begin
								hdr_bad_n = 1'b1;
							end
							hdr_pos_n = hdr_pos_q + 6'd1;
						end else begin
							hdr_bad_n = 1'b1;
						end
					end else if (hdr_bad_q || hdr_pos_q != 6'(HEADER_LENGTH)) begin
						phase_n = PH_STOP;
						res0.kind = KIND_ERROR;
						res0.error_code = ERR_HEADER;
						res0.row_line = 32'd1;
						n_res = 2'd1;
					end else if (cmd) begin
						phase_n = PH_STOP;
						res0 = done_res;
						n_res = 2'd1;
					end else begin
						phase_n = PH_ROWS;
						if (line_q != '1) begin
							line_n = line_q + 1'b1;
						end
					end
				end
				PH_ROWS: begin
					if (cmd) begin
						phase_n = PH_STOP;
						if (raw_len_q != '0) begin
							res0 = fin;
							if (fin_err) begin
								n_res = 2'd1;
							end else begin
								res1 = done_res;
								n_res = 2'd2;
							end
						end else begin
							res0 = done_res;
							n_res = 2'd1;
						end
					end else if (file_byte == CH_NEWLINE) begin
						if (raw_len_q != '0) begin
							res0 = fin;
							n_res = 2'd1;
							if (fin_err) begin
								phase_n = PH_STOP;
							end
						end
						raw_len_n = '0;
						esc_n     = 1'b0;
						tabs_n    = 3'd0;
						id_seen_n = 1'b0;
						ver_n     = 64'd0;
						ver_bad_n = 1'b0;
						ver_dig_n = 1'b0;
						del_len_n = 2'd0;
						del_val_n = 1'b0;
						if (line_q != '1) begin
							line_n = line_q + 1'b1;
						end
					end else begin
						if (raw_len_q != '1) begin
							raw_len_n = raw_len_q + 1'b1;
						end
						if (esc_q && !esc_ok) begin
							esc_n = 1'b0;
							phase_n = PH_STOP;
							res0.kind = KIND_ERROR;
							res0.error_code = ERR_ESCAPE;
							res0.row_line = line_num;
							res0.error_column = len_clamp;
							n_res = 2'd1;
						end else if (!esc_q && file_byte == CH_BACKSLASH) begin
							esc_n = 1'b1;
						end else if (!esc_q && file_byte == CH_TAB) begin
							if (tabs_q != 3'd7) begin
								tabs_n = tabs_q + 3'd1;
							end
						end else begin
							esc_n = 1'b0;
							res0 = data_res;
							n_res = 2'd1;
							case (tabs_q)
								3'd0: id_seen_n = 1'b1;
								3'd1: begin
									if (is_digit) begin
										ver_dig_n = 1'b1;
										if (!ver_bad_q) begin
											if (ver_q > ver_limit) begin
												ver_bad_n = 1'b1;
											end else begin
												ver_n = ver_next;
											end
										end
									end else begin
										ver_bad_n = 1'b1;
									end
								end
								3'd2: begin
									if (del_len_q == 2'd0 && (dec == CH_ZERO || dec == CH_ONE)) begin
										del_len_n = 2'd1;
										del_val_n = dec[0];
									end else begin
										del_len_n = 2'd2;
									end
								end
								default: ;
							endcase
						end
					end
				end
				default: ;
			endcase
		end
		res0.last = (n_res == 2'd1);
		res1.last = (n_res == 2'd2);
	end

	assign push.count  = n_res;
	assign push.first  = res0;
	assign push.second = res1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_pos_q <= 6'd0;
			hdr_bad_q <= 1'b0;
			line_q    <= LINE_BITS'(1);
			raw_len_q <= '0;
			esc_q     <= 1'b0;
			tabs_q    <= 3'd0;
			id_seen_q <= 1'b0;
			ver_q     <= 64'd0;
			ver_bad_q <= 1'b0;
			ver_dig_q <= 1'b0;
			del_len_q <= 2'd0;
			del_val_q <= 1'b0;
		end else begin
			phase_q   <= phase_n;
			hdr_pos_q <= hdr_pos_n;
			hdr_bad_q <= hdr_bad_n;
			line_q    <= line_n;
			raw_len_q <= raw_len_n;
			esc_q     <= esc_n;
			tabs_q    <= tabs_n;
			id_seen_q <= id_seen_n;
			ver_q     <= ver_n;
			ver_bad_q <= ver_bad_n;
			ver_dig_q <= ver_dig_n;
			del_len_q <= del_len_n;
			del_val_q <= del_val_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_STOP |=> phase_q == PH_STOP)
		else $error("left stopped phase");

	a_error_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(n_res != 2'd0 && res0.kind == KIND_ERROR) |=> phase_q == PH_STOP)
		else $error("error result without stop");

	a_two_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		n_res == 2'd2 |-> (cmd && res1.kind == KIND_DONE && res0.kind == KIND_ROW))
		else $error("two results outside end of input");
`endif

endmodule

// ===== design/etsv_out_buf.sv =====
module etsv_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  etsv_pkg::push_t   push,
	output logic              room,
	output logic              head_valid,
	input  logic              head_ready,
	output etsv_pkg::result_t head
);
	import etsv_pkg::*;

	result_t    slot_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] count_q;
	logic       pop;

	assign head_valid = (count_q != 3'd0);
	assign head       = slot_q[rd_q];
	assign pop        = head_valid && head_ready;
	assign room       = (count_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			slot_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			slot_q[wr_q + 2'd1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 2'd0;
			rd_q    <= 2'd0;
			count_q <= 3'd0;
		end else begin
			wr_q    <= wr_q + push.count;
			rd_q    <= rd_q + 2'(pop);
			count_q <= count_q + 3'(push.count) - 3'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result buffer overflow");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> room)
		else $error("push without room");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd3)
		else $error("bad push count");
`endif

endmodule

// ===== design/escaped_tsv_row_validator.sv =====
// escaped tsv row validator
// input channel s_axis: one transfer per file byte; tuser = 1 marks end of
// input (tdata then ignored), tuser = 0 carries a raw file byte in tdata
// output channel m_axis: tuser gives the result kind (data byte, row
// complete, error, finished); tlast marks the last result of an input byte;
// tdata carries the result fields, packed as listed at the port
// first line is checked against the fixed header; later lines are split on
// tabs, escapes decoded, and each decoded byte is sent with its column
// throughput: one byte per cycle while the output buffer has room; end of input may give two results
// an input register feeds the decode logic, results go to a four-entry
// output buffer; s_axis_tready drops only when that buffer holds three or
// more results, so a stalled receiver backs up into the input after three
// after reset the block expects the header line, line count starts at one
// after an error or a finished result the block ignores all input until reset
module escaped_tsv_row_validator #(
	parameter int LENGTH_BITS = 16,
	parameter int LINE_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,  // file_byte
	input  logic                               s_axis_tuser,  // cmd
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// data_byte, column_index, line number, version_value, deleted_flag,
	// error_code, error_column, zero pad
	output logic [etsv_pkg::TDATA_BITS-1:0]    m_axis_tdata,
	output logic [1:0]                         m_axis_tuser,  // kind
	output logic                               m_axis_tlast
);
	import etsv_pkg::*;

	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;
	logic       room;
	logic       fire_s1;
	logic       in_fire;
	push_t      push;
	result_t    head;

	assign fire_s1       = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1  <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	etsv_parse #(
		.LENGTH_BITS(LENGTH_BITS),
		.LINE_BITS(LINE_BITS)
	) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire_s1),
		.cmd(cmd_s1),
		.file_byte(byte_s1),
		.push(push)
	);

	etsv_out_buf u_out (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.head_valid(m_axis_tvalid),
		.head_ready(m_axis_tready),
		.head(head)
	);

	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;
	assign m_axis_tdata = {1'b0, head.error_column, head.error_code, head.deleted_flag,
		head.version_value, head.row_line, head.column_index, head.data_byte};

endmodule
